/* rtl/core/rca_pkg.sv */
// Shared types, widths and codes of the rotatable circular array.
package rca_pkg;

   // Fixed port widths
   localparam int MODE_W   = 2;
   localparam int SHIFT_W  = 8;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Step counter width of the remainder unit (one dividend bit per step)
   localparam int STEP_W = $clog2(INDEX_W);

   // Parameter defaults
   localparam int DEF_CAPACITY   = 16;
   localparam int DEF_DATA_WIDTH = 32;

   typedef enum logic [MODE_W-1:0] {
      MODE_ROTATE = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_READ   = 2'd2
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // Controller to datapath
   typedef struct packed {
      logic latch;      // capture the request beat
      logic div_start;  // start remainder of the selected operand
      logic rot_apply;  // move head by the rotation amount
      logic ptr_load;   // shift pointer := count
      logic shift_rd;   // read entry ptr-1
      logic shift_wr;   // write entry ptr from read data, ptr--
      logic ins_write;  // store insert value, bump count (and head)
      logic rd_issue;   // read entry at logical position
      logic rsp_fire;   // register the result beat
      logic rsp_data;   // result carries the read word
      logic set_full;
      logic set_empty;
   } rca_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_rot;
      logic is_ins;
      logic is_rd;
      logic empty;
      logic full;
      logic head_zero;
      logic ptr_above_head;
      logic div_done;
   } rca_sts_type;

endpackage

/* rtl/core/rotatable_circular_array_unit.sv */
// Top level of the rotatable circular array: controller plus datapath.
//
// Usage: raise start with req_mode and its operands while busy is low; the
// beat is taken at that clock edge and busy rises for the rest of the work.
// Modes: rotate moves the head by req_shift_amount mod count, insert appends
// req_insert_value at the logical end, read returns logical entry
// req_read_index mod count.
// Every beat produces exactly one result: rsp_strobe is high for one cycle
// with rsp_read_value, rsp_status and rsp_element_count. The receiver cannot
// stall; the result sits in an output register, so a new beat may be started
// in the cycle the strobe is shown.
// Rotate and read run the remainder unit, which takes one index bit per
// cycle, 8 bits; insert with head at zero writes directly; insert with head
// h and count c moves c-h entries first, and each entry moved costs one
// memory read and one write on the single port pair; empty/full rejects and
// unused modes answer from the decode state.
// Reset (synchronous, active high) clears head, count and the controller;
// the entry memory is not cleared and is only read below the count.
module rotatable_circular_array_unit
   import rca_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic signed [SHIFT_W-1:0] req_shift_amount,
   input  logic [VALUE_W-1:0]  req_insert_value,
   input  logic [INDEX_W-1:0]  req_read_index,
   output logic                rsp_strobe,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_element_count
);

   rca_cmd_type cmd;
   rca_sts_type sts;
   logic        ctl_busy;

   rca_controller u_ctl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (ctl_busy),
      .sts  (sts),
      .cmd  (cmd)
   );

   rca_datapath #(
      .CAPACITY  (CAPACITY),
      .DATA_WIDTH(DATA_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_mode         (req_mode),
      .req_shift_amount (req_shift_amount),
      .req_insert_value (req_insert_value),
      .req_read_index   (req_read_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_read_value   (rsp_read_value),
      .rsp_status       (rsp_status),
      .rsp_element_count(rsp_element_count)
   );

   assign busy = ctl_busy;

endmodule

/* rtl/core/rca_divider.sv */
// Iterative remainder unit: dividend mod divisor, one dividend bit per cycle.
module rca_divider
   import rca_pkg::*;
#(
   parameter int CNT_W = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [INDEX_W-1:0] dividend,
   input  logic [CNT_W-1:0]   divisor,
   output logic [CNT_W-1:0]   remainder,
   output logic               done
);

   logic [CNT_W-1:0]   rem_ff, rem_in;
   logic [INDEX_W-1:0] sh_ff, sh_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W:0]     trial;

   // Restoring step: bring in next bit, subtract divisor if it fits
   always_comb begin
      trial   = {rem_ff, sh_ff[INDEX_W-1]};
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = '0;
         sh_in   = dividend;
         step_in = '0;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = CNT_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = CNT_W'(trial);
         end
         sh_in   = sh_ff << 1;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(INDEX_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

/* rtl/core/rca_datapath.sv */
// Datapath: entry memory, head, count, shift pointer, remainder unit, result registers.
module rca_datapath
   import rca_pkg::*;
#(
   parameter int CAPACITY   = DEF_CAPACITY,
   parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
   input  logic                clock,
   input  logic                reset,
   input  rca_cmd_type         cmd,
   output rca_sts_type         sts,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic signed [SHIFT_W-1:0] req_shift_amount,
   input  logic [VALUE_W-1:0]  req_insert_value,
   input  logic [INDEX_W-1:0]  req_read_index,
   output logic                rsp_strobe,
   output logic [VALUE_W-1:0]  rsp_read_value,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [COUNT_W-1:0]  rsp_element_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Request beat
   logic [MODE_W-1:0]  mode_ff;
   logic [SHIFT_W-1:0] shift_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [INDEX_W-1:0] index_ff;

   // Array state
   logic [AW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] ptr_ff, ptr_in;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];
   logic [DATA_WIDTH-1:0] mem_rd_ff;
   logic [AW-1:0]         rd_addr;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  wr_en;

   // Remainder unit
   logic                neg;
   logic [INDEX_W-1:0]  div_operand;
   logic [CW-1:0]       div_rem;
   logic                div_done;

   // Position arithmetic
   logic [CW-1:0] amount;
   logic [CW:0]   pos_sum;
   logic [CW:0]   pos_wrap;
   logic [AW-1:0] new_pos;

   logic rsp_strobe_ff;
   logic [VALUE_W-1:0]  rsp_value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   assign neg = shift_ff[SHIFT_W-1];

   // Dividend: magnitude of a negative shift, the shift itself, or the read index
   always_comb begin
      if (mode_ff == MODE_ROTATE) begin
         div_operand = neg ? (~shift_ff + 1'b1) : shift_ff;
      end else begin
         div_operand = index_ff;
      end
   end

   rca_divider #(
      .CNT_W(CW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_operand),
      .divisor  (count_ff),
      .remainder(div_rem),
      .done     (div_done)
   );

   // Head plus offset, wrapped once (both terms stay below count)
   always_comb begin
      if (mode_ff == MODE_ROTATE && neg) begin
         amount = (div_rem == '0) ? '0 : CW'(count_ff - div_rem);
      end else begin
         amount = div_rem;
      end
      pos_sum = {1'b0, CW'(head_ff)} + {1'b0, amount};
      if (pos_sum >= {1'b0, count_ff}) begin
         pos_wrap = pos_sum - {1'b0, count_ff};
      end else begin
         pos_wrap = pos_sum;
      end
      new_pos = AW'(pos_wrap);
   end

   // Memory port selection
   always_comb begin
      rd_addr = cmd.shift_rd ? AW'(ptr_ff - 1'b1) : new_pos;
      wr_en   = cmd.shift_wr || cmd.ins_write;
      if (cmd.shift_wr) begin
         wr_addr = ptr_ff;
         wr_data = mem_rd_ff;
      end else begin
         wr_addr = (head_ff == '0) ? AW'(count_ff) : head_ff;
         wr_data = DATA_WIDTH'(value_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.shift_rd || cmd.rd_issue) begin
         mem_rd_ff <= mem[rd_addr];
      end
   end

   // Head, count and shift pointer updates
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      if (cmd.rot_apply) begin
         head_in = new_pos;
      end
      if (cmd.ptr_load) begin
         ptr_in = AW'(count_ff);
      end
      if (cmd.shift_wr) begin
         ptr_in = ptr_ff - 1'b1;
      end
      if (cmd.ins_write) begin
         count_in = count_ff + 1'b1;
         if (head_ff != '0) begin
            head_in = head_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= cmd.rsp_fire;
      end
      ptr_ff <= ptr_in;
      if (cmd.latch) begin
         mode_ff  <= req_mode;
         shift_ff <= req_shift_amount;
         value_ff <= req_insert_value;
         index_ff <= req_read_index;
      end
      // Result beat
      if (cmd.rsp_fire) begin
         rsp_value_ff <= cmd.rsp_data ? VALUE_W'(mem_rd_ff) : '0;
         if (cmd.set_full) begin
            rsp_status_ff <= STATUS_FULL;
         end else if (cmd.set_empty) begin
            rsp_status_ff <= STATUS_EMPTY;
         end else begin
            rsp_status_ff <= STATUS_OK;
         end
         rsp_count_ff <= COUNT_W'(count_ff);
      end
   end

   // Status towards the controller
   always_comb begin
      sts.is_rot         = (mode_ff == MODE_ROTATE);
      sts.is_ins         = (mode_ff == MODE_INSERT);
      sts.is_rd          = (mode_ff == MODE_READ);
      sts.empty          = (count_ff == '0);
      sts.full           = (count_ff >= CW'(CAPACITY));
      sts.head_zero      = (head_ff == '0);
      sts.ptr_above_head = (ptr_ff > head_ff);
      sts.div_done       = div_done;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_read_value    = rsp_value_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_element_count = rsp_count_ff;

endmodule

/* rtl/core/rca_controller.sv */
// Controller: sequences rotate, insert (with entry shifting) and read operations.
module rca_controller
   import rca_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  rca_sts_type sts,
   output rca_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_DIV_WAIT,
      ST_RD_WAIT,
      ST_SH_CHK,
      ST_SH_WR,
      ST_RESPOND
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (sts.is_rot || sts.is_rd) begin
               if (sts.empty) begin
                  cmd.set_empty = 1'b1;
                  cmd.rsp_fire  = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = ST_DIV_WAIT;
               end
            end else if (sts.is_ins) begin
               if (sts.full) begin
                  cmd.set_full = 1'b1;
                  cmd.rsp_fire = 1'b1;
                  state_in     = ST_IDLE;
               end else if (sts.head_zero) begin
                  cmd.ins_write = 1'b1;
                  state_in      = ST_RESPOND;
               end else begin
                  cmd.ptr_load = 1'b1;
                  state_in     = ST_SH_CHK;
               end
            end else begin
               // unused mode: plain ok beat
               cmd.rsp_fire = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DIV_WAIT: begin
            if (sts.div_done) begin
               if (sts.is_rot) begin
                  cmd.rot_apply = 1'b1;
                  state_in      = ST_RESPOND;
               end else begin
                  cmd.rd_issue = 1'b1;
                  state_in     = ST_RD_WAIT;
               end
            end
         end
         ST_RD_WAIT: begin
            cmd.rsp_fire = 1'b1;
            cmd.rsp_data = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SH_CHK: begin
            if (sts.ptr_above_head) begin
               cmd.shift_rd = 1'b1;
               state_in     = ST_SH_WR;
            end else begin
               cmd.ins_write = 1'b1;
               state_in      = ST_RESPOND;
            end
         end
         ST_SH_WR: begin
            cmd.shift_wr = 1'b1;
            state_in     = ST_SH_CHK;
         end
         ST_RESPOND: begin
            cmd.rsp_fire = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= (state_in != ST_IDLE);
      end
   end

   assign busy = busy_ff;

endmodule

/* dv/tb_rotatable_circular_array_unit.sv */
// Self-checking testbench for the rotatable circular array unit.
`timescale 1ns / 100ps

module tb_rotatable_circular_array_unit;
   import rca_pkg::*;

   localparam int CAP = DEF_CAPACITY;
   localparam int RANDOM_OPS = 900;
   localparam int SETTLE_CYCLES = 50;
   localparam int CYCLE_LIMIT = 400000;
   // Encoding with no operation behind it; the unit answers it with no change
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct {
      logic [MODE_W-1:0]         mode;
      logic signed [SHIFT_W-1:0] shift;
      logic [VALUE_W-1:0]        value;
      logic [INDEX_W-1:0]        index;
      int                        gap;    // idle cycles before the beat
      bit                        drain;  // hold the beat until all results are back
   } array_op_type;

   typedef struct {
      logic [VALUE_W-1:0] read_value;
      status_type         status;
      logic [COUNT_W-1:0] element_count;
   } array_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [MODE_W-1:0] req_mode = '0;
   logic signed [SHIFT_W-1:0] req_shift_amount = '0;
   logic [VALUE_W-1:0] req_insert_value = '0;
   logic [INDEX_W-1:0] req_read_index = '0;
   logic rsp_strobe;
   logic [VALUE_W-1:0] rsp_read_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0] rsp_element_count;

   array_op_type queued_ops[$];
   array_result_type due_results[$];
   int total_ops = 0;
   int fill_level = 0;
   int mismatches = 0;
   int cycle_count = 0;

   // Shadow copy of the array contents and pointers
   logic [VALUE_W-1:0] shadow_store [CAP];
   int shadow_head = 0;
   int shadow_count = 0;

   rotatable_circular_array_unit u_top (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_shift_amount  (req_shift_amount),
      .req_insert_value  (req_insert_value),
      .req_read_index    (req_read_index),
      .rsp_strobe        (rsp_strobe),
      .rsp_read_value    (rsp_read_value),
      .rsp_status        (rsp_status),
      .rsp_element_count (rsp_element_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Applies one operation to the shadow array and returns the answer it gives
   function automatic array_result_type predict_array_op(input logic [MODE_W-1:0] mode,
                                                      input logic signed [SHIFT_W-1:0] shift,
                                                      input logic [VALUE_W-1:0] value,
                                                      input logic [INDEX_W-1:0] index);
      array_result_type res;
      int amount;
      res.read_value = '0;
      res.status = STATUS_OK;
      case (mode)
         MODE_ROTATE: begin
            if (shadow_count == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               // true modulo, so negative shifts wrap forwards
               amount = int'(shift) % shadow_count;
               if (amount < 0) amount += shadow_count;
               shadow_head = (shadow_head + amount) % shadow_count;
            end
         end
         MODE_INSERT: begin
            if (shadow_count >= CAP) begin
               res.status = STATUS_FULL;
            end else if (shadow_head == 0) begin
               shadow_store[shadow_count] = value;
               shadow_count++;
            end else begin
               // open a slot at head, the new word becomes the logical tail
               for (int i = shadow_count; i > shadow_head; i--)
                  shadow_store[i] = shadow_store[i-1];
               shadow_store[shadow_head] = value;
               shadow_head++;
               shadow_count++;
            end
         end
         MODE_READ: begin
            if (shadow_count == 0)
               res.status = STATUS_EMPTY;
            else
               res.read_value =
                  shadow_store[(shadow_head + int'(index) % shadow_count) % shadow_count];
         end
         default: ;
      endcase
      res.element_count = shadow_count[COUNT_W-1:0];
      return res;
   endfunction

   // Stimulus list builder; tracks the fill level to steer the random mix
   task automatic push_op(input logic [MODE_W-1:0] mode, input int shift,
                          input logic [VALUE_W-1:0] value, input int index,
                          input int gap, input bit drain);
      array_op_type op;
      op.mode = mode;
      op.shift = shift[SHIFT_W-1:0];
      op.value = value;
      op.index = index[INDEX_W-1:0];
      op.gap = gap;
      op.drain = drain;
      queued_ops.insert(queued_ops.size(), op);
      total_ops++;
      if (mode == MODE_INSERT && fill_level < CAP) fill_level++;
   endtask

   // Driver: presents queued beats, honouring idle gaps and drain requests
   array_op_type next_op;
   bit holding = 1'b0;
   bit presenting = 1'b0;
   int gap_left = 0;
   int beats_taken = 0;
   int beats_back = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         holding = 1'b0;
         presenting = 1'b0;
         gap_left = 0;
      end else begin
         if (rsp_strobe) beats_back++;
         if (start && !busy) begin
            beats_taken++;
            presenting = 1'b0;
         end
         if (!presenting) begin
            if (!holding && queued_ops.size() != 0) begin
               next_op = queued_ops.pop_front();
               holding = 1'b1;
               gap_left = next_op.gap;
            end
            if (holding) begin
               if (gap_left != 0) begin
                  gap_left--;
               end else if (!next_op.drain || beats_back >= beats_taken) begin
                  req_mode <= next_op.mode;
                  req_shift_amount <= next_op.shift;
                  req_insert_value <= next_op.value;
                  req_read_index <= next_op.index;
                  presenting = 1'b1;
                  holding = 1'b0;
               end
            end
         end
         start <= presenting;
      end
   end

   // Monitor: checks each result beat, then predicts any beat accepted here
   array_result_type want;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            if (due_results.size() == 0) begin
               mismatches++;
               $display("%0t: result beat with none due: value %h status %0d count %0d",
                        $time, rsp_read_value, rsp_status, rsp_element_count);
            end else begin
               want = due_results.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  mismatches++;
                  $display("%0t: rsp_read_value expected %h, actual %h",
                           $time, want.read_value, rsp_read_value);
               end
               if (rsp_status !== want.status) begin
                  mismatches++;
                  $display("%0t: rsp_status expected %0d, actual %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_element_count !== want.element_count) begin
                  mismatches++;
                  $display("%0t: rsp_element_count expected %0d, actual %0d",
                           $time, want.element_count, rsp_element_count);
               end
            end
         end
         if (start && !busy)
            due_results.insert(due_results.size(),
                               predict_array_op(req_mode, req_shift_amount,
                                                req_insert_value, req_read_index));
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Stimulus and end of run
   initial begin
      int pick;
      int ins_pct;
      int gap;
      bit quiet;
      logic [VALUE_W-1:0] word;

      // directed: empty-store cases, first inserts, wrap-around and extremes
      push_op(MODE_ROTATE, 5, 32'h0, 0, 0, 0);
      push_op(MODE_READ, 0, 32'h0, 0, 0, 0);
      push_op(MODE_UNUSED, -1, 32'hFFFF_FFFF, 255, 0, 0);
      push_op(MODE_INSERT, 0, 32'h0000_0000, 0, 0, 0);
      push_op(MODE_READ, 0, 32'h0, 255, 2, 0);
      push_op(MODE_ROTATE, -128, 32'h0, 0, 0, 0);
      push_op(MODE_INSERT, 0, 32'hFFFF_FFFF, 0, 0, 0);
      push_op(MODE_INSERT, 0, 32'hA5A5_A5A5, 0, 1, 0);
      push_op(MODE_ROTATE, 1, 32'h0, 0, 0, 0);
      push_op(MODE_INSERT, 0, 32'h5A5A_5A5A, 0, 0, 0);
      push_op(MODE_ROTATE, 127, 32'h0, 0, 0, 0);
      push_op(MODE_ROTATE, -1, 32'h0, 0, 3, 0);
      push_op(MODE_INSERT, 0, 32'h1234_5678, 0, 0, 0);
      push_op(MODE_READ, 0, 32'h0, 0, 0, 0);
      push_op(MODE_READ, 0, 32'h0, 255, 0, 0);
      push_op(MODE_READ, 0, 32'h0, 4, 0, 0);
      push_op(MODE_UNUSED, 85, 32'h0F0F_0F0F, 170, 0, 0);
      push_op(MODE_ROTATE, -128, 32'h0, 0, 0, 0);
      push_op(MODE_INSERT, 0, 32'h8000_0000, 0, 0, 1);
      push_op(MODE_READ, 0, 32'h0, 128, 0, 0);

      // random: fill gradually with rotates mixed in, then work the full store
      for (int i = 0; i < RANDOM_OPS; i++) begin
         quiet = ((i / 60) % 3 == 2) || (i >= RANDOM_OPS - 140);
         gap = (!quiet && $urandom_range(0, 2) == 0) ? $urandom_range(1, 17) : 0;
         ins_pct = (fill_level < CAP) ? 40 : 20;
         pick = $urandom_range(0, 99);
         case ($urandom_range(0, 7))
            0: word = '0;
            1: word = '1;
            default: word = $urandom;
         endcase
         if (pick < 3)
            push_op(MODE_UNUSED, $urandom_range(0, 255), word, $urandom_range(0, 255),
                    gap, i % 200 == 100);
         else if (pick < 3 + ins_pct)
            push_op(MODE_INSERT, $urandom_range(0, 255), word, $urandom_range(0, 255),
                    gap, i % 200 == 100);
         else if (pick < 70)
            push_op(MODE_ROTATE, $urandom_range(0, 255), word, $urandom_range(0, 255),
                    gap, i % 200 == 100);
         else
            push_op(MODE_READ, $urandom_range(0, 255), word,
                    ($urandom_range(0, 1) != 0) ? $urandom_range(0, CAP - 1)
                                               : $urandom_range(0, 255),
                    gap, i % 200 == 100);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      wait (beats_back >= total_ops);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_results.size() != 0)
         $display("%0t: %0d results still due at end of run", $time, due_results.size());
      if (mismatches == 0 && due_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
